[hw/rtl/a2h_pkg.sv]
// Shared types, character codes and key-mapping functions for the text-to-HID
// report encoder. No dependencies; every other file in hw/rtl imports this.

package a2h_pkg;

	localparam int JOBQ_DEPTH = 2;

	// Bytes with a fixed meaning
	localparam logic [7:0] CH_END   = 8'h00;
	localparam logic [7:0] CH_CTRL  = 8'h03;
	localparam logic [7:0] CH_ALT   = 8'h04;
	localparam logic [7:0] CH_GUI   = 8'h05;
	localparam logic [7:0] CH_PAUSE = 8'h07;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0a;

	localparam logic [7:0] MOD_LSHIFT = 8'h02;

	localparam logic [7:0] KEY_NONE    = 8'h00;
	localparam logic [7:0] KEY_RETURN  = 8'h28;
	localparam logic [7:0] KEY_TAB     = 8'h2b;
	localparam logic [7:0] KEY_PERCENT = 8'h22;
	localparam logic [7:0] KEY_ZERO    = 8'h27;
	localparam logic [7:0] KEY_LBRACK  = 8'h30;
	localparam logic [7:0] KEY_RBRACK  = 8'h32;
	localparam logic [7:0] KEY_YEN     = 8'h87;
	localparam logic [7:0] KEY_CARET   = 8'h2e;
	localparam logic [7:0] KEY_BAR     = 8'h89;
	localparam logic [7:0] KEY_A       = 8'h04;

	// {modifier, usage} for ' ' through '?'
	localparam logic [15:0] SYM_TAB [32] = '{
		16'h002c, 16'h021e, 16'h021f, 16'h0220,
		16'h0221, 16'h0222, 16'h0223, 16'h0224,
		16'h0225, 16'h0226, 16'h0234, 16'h0233,
		16'h0036, 16'h002d, 16'h0037, 16'h0038,
		16'h0027, 16'h001e, 16'h001f, 16'h0020,
		16'h0021, 16'h0022, 16'h0023, 16'h0024,
		16'h0025, 16'h0026, 16'h0034, 16'h0033,
		16'h0236, 16'h022d, 16'h0237, 16'h0238
	};

	typedef struct packed {
		logic [7:0] modifier;
		logic [7:0] usage;
	} a2h_rpt_t;

	// One classified byte waiting for the back end
	typedef struct packed {
		logic [7:0] modifier;
		logic [7:0] usage;
		logic       pause;
		logic       endm;
		logic       is_hex;
		logic [7:0] chr;
	} a2h_job_t;

	function automatic a2h_rpt_t map_char(logic [7:0] c);
		a2h_rpt_t r;
		r = '0;
		priority if (c == CH_LF) begin
			r.usage = KEY_RETURN;
		end else if (c == CH_TAB) begin
			r.usage = KEY_TAB;
		end else if (c >= 8'h61 && c <= 8'h7a) begin
			r.usage = c - 8'h5d;
		end else if (c >= 8'h41 && c <= 8'h5a) begin
			r.modifier = MOD_LSHIFT;
			r.usage = c - 8'h3d;
		end else if (c >= 8'h20 && c <= 8'h3f) begin
			r.modifier = SYM_TAB[c[4:0]][15:8];
			r.usage = SYM_TAB[c[4:0]][7:0];
		end else if (c == 8'h5b) begin
			r.usage = KEY_LBRACK;
		end else if (c == 8'h5d) begin
			r.usage = KEY_RBRACK;
		end else if (c == 8'h7b) begin
			r.modifier = MOD_LSHIFT;
			r.usage = KEY_LBRACK;
		end else if (c == 8'h7d) begin
			r.modifier = MOD_LSHIFT;
			r.usage = KEY_RBRACK;
		end else if (c == 8'h5c) begin
			r.usage = KEY_YEN;
		end else if (c == 8'h5e) begin
			r.usage = KEY_CARET;
		end else if (c == 8'h7c) begin
			r.modifier = MOD_LSHIFT;
			r.usage = KEY_BAR;
		end else begin
			r = '0;
		end
		return r;
	endfunction

	// Report for one upper-case hex digit
	function automatic a2h_rpt_t hex_key(logic [3:0] n);
		a2h_rpt_t r;
		r = '0;
		if (n == 4'd0) begin
			r.usage = KEY_ZERO;
		end else if (n < 4'd10) begin
			r.usage = 8'h1d + {4'b0, n};
		end else begin
			r.modifier = MOD_LSHIFT;
			r.usage = KEY_A + {4'b0, n} - 8'd10;
		end
		return r;
	endfunction

	// Pending bits {gui, alt, ctrl} placed into the HID modifier byte
	function automatic logic [7:0] pend_to_hid(logic [2:0] p);
		return {4'b0, p[2], p[1], 1'b0, p[0]};
	endfunction

endpackage

[hw/rtl/a2h_front.sv]
// Front end: takes text bytes, keeps the pending prefix modifiers and turns
// each non-prefix byte into one job for the queue. Uses a2h_pkg.

module a2h_front
	import a2h_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [7:0] char_byte,
	output logic       job_valid,
	output a2h_job_t   job
);

	logic [2:0] pend_q;
	logic       is_prefix;
	a2h_rpt_t   rpt;

	assign is_prefix = (char_byte == CH_CTRL) || (char_byte == CH_ALT) ||
		(char_byte == CH_GUI);

	always_comb begin
		rpt = map_char(char_byte);
		job = '0;
		job.chr = char_byte;
		job_valid = take && !is_prefix;
		priority if (char_byte == CH_END) begin
			job.endm = 1'b1;
		end else if (char_byte[7]) begin
			// '%' first, then two hex digits from the back end
			job.is_hex = 1'b1;
			job.modifier = MOD_LSHIFT | pend_to_hid(pend_q);
			job.usage = KEY_PERCENT;
		end else begin
			job.modifier = rpt.modifier | pend_to_hid(pend_q);
			job.usage = rpt.usage;
			job.pause = (char_byte == CH_PAUSE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else if (take) begin
			priority if (char_byte == CH_CTRL) begin
				pend_q <= pend_q | 3'b001;
			end else if (char_byte == CH_ALT) begin
				pend_q <= pend_q | 3'b010;
			end else if (char_byte == CH_GUI) begin
				pend_q <= pend_q | 3'b100;
			end else begin
				pend_q <= '0;
			end
		end
	end

endmodule

[hw/rtl/a2h_jobq.sv]
// Short job queue between front and back end, register based.
// Uses a2h_pkg for the job type.

module a2h_jobq
	import a2h_pkg::*;
#(
	parameter int DEPTH = JOBQ_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     wr,
	input  a2h_job_t wr_job,
	input  logic     rd,
	output logic     full,
	output logic     head_valid,
	output a2h_job_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	a2h_job_t        mem_q [DEPTH];
	logic [PW-1:0]   wptr_q;
	logic [PW-1:0]   rptr_q;
	logic [CW-1:0]   cnt_q;

	assign full = (cnt_q == CW'(DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head = mem_q[rptr_q];

	function automatic logic [PW-1:0] bump(logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (wr) begin
			mem_q[wptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) begin
				wptr_q <= bump(wptr_q);
			end
			if (rd) begin
				rptr_q <= bump(rptr_q);
			end
			unique case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full && !rd |-> !wr) else $error("job queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd |-> head_valid) else $error("job queue read while empty");

endmodule

[hw/rtl/a2h_back.sv]
// Back end: expands jobs into HID reports (one, or three for a percent
// encoded byte) and holds the oldest report in the output register.
// Uses a2h_pkg.

module a2h_back
	import a2h_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  a2h_job_t   head,
	output logic       head_rd,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] modifier_bits,
	output logic [7:0] key_usage,
	output logic       pause_mark,
	output logic       end_mark,
	output logic       last_of_run
);

	logic [1:0] step_q;
	logic       out_valid_q;
	logic       load;
	logic       last;
	a2h_rpt_t   rpt;

	assign empty = !out_valid_q;
	assign load = head_valid && (!out_valid_q || pop);

	always_comb begin
		unique case (step_q)
			2'd1: begin
				rpt = hex_key(head.chr[7:4]);
				last = 1'b0;
			end
			2'd2: begin
				rpt = hex_key(head.chr[3:0]);
				last = 1'b1;
			end
			default: begin
				rpt.modifier = head.modifier;
				rpt.usage = head.usage;
				last = !head.is_hex;
			end
		endcase
	end

	assign head_rd = load && last;

	always_ff @(posedge clk) begin
		if (load) begin
			modifier_bits <= rpt.modifier;
			key_usage <= rpt.usage;
			pause_mark <= (step_q == 2'd0) && head.pause;
			end_mark <= (step_q == 2'd0) && head.endm;
			last_of_run <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			// advance through the digits, back to zero on the last report
			if (load) begin
				step_q <= last ? 2'd0 : step_q + 2'd1;
			end
		end
	end

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q != 2'd3) else $error("report step out of range");
	a_step_holds_job: assert property (@(posedge clk) disable iff (!arst_n)
		step_q != 2'd0 |-> head_valid && head.is_hex)
		else $error("hex expansion lost its job");
	a_output_held: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !pop |=> out_valid_q && $stable(key_usage))
		else $error("waiting report changed");

endmodule

[hw/rtl/ascii_to_hid_keystroke_encoder.sv]
// Top level of the text-to-HID report encoder: front end, job queue and
// back end. Depends on a2h_pkg, a2h_front, a2h_jobq and a2h_back.

// Takes one text byte per cycle while full is low and delivers HID reports
// (modifier byte, key usage, pause/end/last marks) through a one-entry output
// register read with pop. Prefix bytes 0x03/0x04/0x05 produce no report and
// add Ctrl/Alt/GUI to the next report (not to the end report of 0x00). A byte
// of 0x80 or more gives three reports and holds the back-end sequencer until
// its last report is loaded, the queue and pop backpressure absorbing the
// difference. Each byte's job is written to the job queue and its reports
// then to the output register. Sustained rate is one report per cycle while
// pop is held high, set by the single back-end report sequencer.

module ascii_to_hid_keystroke_encoder
	import a2h_pkg::*;
#(
	parameter int JOBQ_DEPTH_P = JOBQ_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] modifier_bits,
	output logic [7:0] key_usage,
	output logic       pause_mark,
	output logic       end_mark,
	output logic       last_of_run
);

	logic     take;
	logic     job_valid;
	a2h_job_t job;
	logic     head_valid;
	logic     head_rd;
	a2h_job_t head;

	assign take = push && !full;

	a2h_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.char_byte (char_byte),
		.job_valid (job_valid),
		.job       (job)
	);

	a2h_jobq #(
		.DEPTH (JOBQ_DEPTH_P)
	) u_jobq (
		.clk        (clk),
		.arst_n     (arst_n),
		.wr         (job_valid),
		.wr_job     (job),
		.rd         (head_rd),
		.full       (full),
		.head_valid (head_valid),
		.head       (head)
	);

	a2h_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.head_rd       (head_rd),
		.empty         (empty),
		.pop           (pop),
		.modifier_bits (modifier_bits),
		.key_usage     (key_usage),
		.pause_mark    (pause_mark),
		.end_mark      (end_mark),
		.last_of_run   (last_of_run)
	);

endmodule

[test/ascii_to_hid_keystroke_encoder_tb.sv]
// Self-checking testbench for the text-to-HID report encoder: drives text bytes
// through the push/full side, predicts every report and checks each pop against it.
// Depends on a2h_pkg and the ascii_to_hid_keystroke_encoder RTL.

module ascii_to_hid_keystroke_encoder_tb;
	import a2h_pkg::*;

	localparam int TEXT_BYTES  = 310;
	localparam int STUCK_LIMIT = 2000;
	localparam int DRAIN_TAIL  = 10;

	localparam logic [7:0] MOD_LCTRL = 8'h01;
	localparam logic [7:0] MOD_LALT  = 8'h04;
	localparam logic [7:0] MOD_LGUI  = 8'h08;

	// usage codes for ' ' through '?', and which of them need shift
	localparam logic [7:0] PUNCT_USAGE [32] = '{
		8'h2c, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
		8'h25, 8'h26, 8'h34, 8'h33, 8'h36, 8'h2d, 8'h37, 8'h38,
		8'h27, 8'h1e, 8'h1f, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24,
		8'h25, 8'h26, 8'h34, 8'h33, 8'h36, 8'h2d, 8'h37, 8'h38
	};
	localparam logic [31:0] PUNCT_SHIFTED = 32'hf000_0ffe;

	localparam logic [7:0] OPENING_BYTES [25] = '{
		CH_END, 8'h7f, 8'hff, 8'h80,
		CH_CTRL, "a",
		CH_GUI, CH_ALT, CH_CTRL, "Z",
		CH_CTRL, CH_CTRL, CH_PAUSE,
		CH_ALT, CH_END,
		CH_GUI, 8'ha5,
		CH_LF, CH_TAB, "@", "_", 8'h60, "~", "{", "|"
	};

	typedef struct packed {
		logic [7:0] mods;
		logic [7:0] usage;
		logic       pause;
		logic       endm;
		logic       last;
	} hid_report_t;

	class keystroke_scoreboard;
		logic [2:0]  held_prefix;	// {gui, alt, ctrl}
		hid_report_t due_reports[$];
		int unsigned mismatches;

		function new();
			held_prefix = '0;
			mismatches = 0;
		endfunction

		function hid_report_t keystroke(logic [7:0] c);
			hid_report_t r;
			r = '0;
			if (c == CH_LF) begin
				r.usage = KEY_RETURN;
			end else if (c == CH_TAB) begin
				r.usage = KEY_TAB;
			end else if (c >= "a" && c <= "z") begin
				r.usage = c - "a" + KEY_A;
			end else if (c >= "A" && c <= "Z") begin
				r.mods = MOD_LSHIFT;
				r.usage = c - "A" + KEY_A;
			end else if (c >= " " && c <= "?") begin
				r.usage = PUNCT_USAGE[c - " "];
				r.mods = PUNCT_SHIFTED[c - " "] ? MOD_LSHIFT : 8'h00;
			end else if (c == "[" || c == "{") begin
				r.usage = KEY_LBRACK;
				r.mods = (c == "{") ? MOD_LSHIFT : 8'h00;
			end else if (c == "]" || c == "}") begin
				r.usage = KEY_RBRACK;
				r.mods = (c == "}") ? MOD_LSHIFT : 8'h00;
			end else if (c == 8'h5c) begin
				r.usage = KEY_YEN;
			end else if (c == "^") begin
				r.usage = KEY_CARET;
			end else if (c == "|") begin
				r.mods = MOD_LSHIFT;
				r.usage = KEY_BAR;
			end
			return r;
		endfunction

		function logic [7:0] prefix_mods();
			return (held_prefix[0] ? MOD_LCTRL : 8'h00) |
				(held_prefix[1] ? MOD_LALT : 8'h00) |
				(held_prefix[2] ? MOD_LGUI : 8'h00);
		endfunction

		function logic [7:0] hex_digit(logic [3:0] n);
			return (n < 4'd10) ? 8'h30 + n : 8'h37 + n;
		endfunction

		function void note_byte(logic [7:0] c);
			hid_report_t r;
			if (c == CH_CTRL) begin
				held_prefix[0] = 1'b1;
			end else if (c == CH_ALT) begin
				held_prefix[1] = 1'b1;
			end else if (c == CH_GUI) begin
				held_prefix[2] = 1'b1;
			end else if (c == CH_END) begin
				r = '0;
				r.endm = 1'b1;
				r.last = 1'b1;
				due_reports.push_back(r);
				held_prefix = '0;
			end else if (c[7]) begin
				// percent-encode: prefixes land on the '%' only
				r = keystroke("%");
				r.mods |= prefix_mods();
				due_reports.push_back(r);
				held_prefix = '0;
				due_reports.push_back(keystroke(hex_digit(c[7:4])));
				r = keystroke(hex_digit(c[3:0]));
				r.last = 1'b1;
				due_reports.push_back(r);
			end else begin
				r = keystroke(c);
				r.mods |= prefix_mods();
				r.pause = (c == CH_PAUSE);
				r.last = 1'b1;
				due_reports.push_back(r);
				held_prefix = '0;
			end
		endfunction

		task report(string what, logic [31:0] got, logic [31:0] want);
			$display("mismatch at %0t: %s got %0h want %0h", $time, what, got, want);
			mismatches++;
		endtask

		task check_report(hid_report_t got);
			hid_report_t want;
			if (due_reports.size() == 0) begin
				report("report with none due", got, 0);
			end else begin
				want = due_reports.pop_front();
				if (got.mods != want.mods)
					report("modifier_bits", got.mods, want.mods);
				if (got.usage != want.usage)
					report("key_usage", got.usage, want.usage);
				if (got.pause != want.pause)
					report("pause_mark", got.pause, want.pause);
				if (got.endm != want.endm)
					report("end_mark", got.endm, want.endm);
				if (got.last != want.last)
					report("last_of_run", got.last, want.last);
			end
		endtask
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       push = 1'b0;
	logic [7:0] char_byte = 8'h00;
	logic       pop = 1'b0;
	logic       full;
	logic       empty;
	logic [7:0] modifier_bits;
	logic [7:0] key_usage;
	logic       pause_mark;
	logic       end_mark;
	logic       last_of_run;

	keystroke_scoreboard sb = new();
	int unsigned stuck_cycles = 0;
	int unsigned pop_step = 0;
	logic [1:0]  pop_mode = 2'd0;
	logic        moved;

	ascii_to_hid_keystroke_encoder uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.char_byte(char_byte),
		.empty(empty),
		.pop(pop),
		.modifier_bits(modifier_bits),
		.key_usage(key_usage),
		.pause_mark(pause_mark),
		.end_mark(end_mark),
		.last_of_run(last_of_run)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 0;
	end

	// receiver: pop_mode picks the stall behavior and is redrawn at random as pop_step advances
	always @(posedge clk) begin
		pop_step++;
		if (pop_step % 64 == 0)
			pop_mode <= 2'($urandom_range(0, 3));
		case (pop_mode)
			2'd0: pop <= 1'b1;
			2'd1: pop <= 1'($urandom_range(0, 1));
			2'd2: pop <= ($urandom_range(0, 4) == 0);
			default: pop <= (pop_step % 8 < 3);
		endcase
	end

	// note every transfer on both sides; end the run if nothing moves for too long
	always @(posedge clk) begin
		if (arst_n) begin
			moved = 1'b0;
			if (push && !full) begin
				sb.note_byte(char_byte);
				moved = 1'b1;
			end
			if (pop && !empty) begin
				sb.check_report({modifier_bits, key_usage, pause_mark, end_mark,
					last_of_run});
				moved = 1'b1;
			end
			stuck_cycles = moved ? 0 : stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic send_byte(input logic [7:0] c);
		push <= 1'b1;
		char_byte <= c;
		do @(posedge clk); while (full);
	endtask

	// drop push and let the last transfer be noted before the queue is checked
	task automatic drain_reports();
		push <= 1'b0;
		@(posedge clk);
		while (sb.due_reports.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] pick_byte();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 12)
			return CH_CTRL + 8'($urandom_range(0, 2));
		else if (sel < 27)
			return 8'($urandom_range(8'h80, 8'hff));
		else if (sel < 70)
			return 8'($urandom_range(8'h20, 8'h7e));
		else if (sel < 80)
			return 8'($urandom_range(0, 8'h1f));
		else if (sel < 84)
			return CH_END;
		else if (sel < 87)
			return CH_PAUSE;
		return 8'($urandom_range(0, 255));
	endfunction

	initial begin : stimulus
		int         typed;
		int         burst;
		bit         paused_once;
		logic [7:0] b;
		typed = 0;
		paused_once = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (OPENING_BYTES[i])
			send_byte(OPENING_BYTES[i]);
		typed = $size(OPENING_BYTES);
		drain_reports();

		while (typed < TEXT_BYTES) begin
			burst = $urandom_range(1, 24);
			repeat (burst) begin
				b = pick_byte();
				send_byte(b);
				typed++;
			end
			if (!paused_once && typed >= TEXT_BYTES / 2) begin
				drain_reports();
				paused_once = 1'b1;
			end else if ($urandom_range(0, 3) != 0) begin
				push <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end
		end

		drain_reports();
		repeat (DRAIN_TAIL) @(posedge clk);
		if (sb.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/a2h_pkg.sv
hw/rtl/a2h_front.sv
hw/rtl/a2h_jobq.sv
hw/rtl/a2h_back.sv
hw/rtl/ascii_to_hid_keystroke_encoder.sv
test/ascii_to_hid_keystroke_encoder_tb.sv
